[rtl/core/mvpcm_pkg.sv]
// ----------------------------------------------------------------------------
// mvpcm_pkg: shared types and constants for the PCM sample player
// Datapath operation codes, tick step numbers, command/status bundles and
// small register map lookups.
// ----------------------------------------------------------------------------
package mvpcm_pkg;

  localparam int VOICES_DEF        = 24;
  localparam int MEM_ADDR_BITS_DEF = 21;
  localparam int RF_DEPTH          = 512;
  localparam int VIDX_W            = 5;
  localparam int OUT_W             = 40;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;
  localparam logic [1:0] FUNC_LOAD  = 2'd3;

  localparam logic [1:0] CHIP_A    = 2'd0;
  localparam logic [1:0] CHIP_B    = 2'd1;
  localparam logic [1:0] CHIP_WORD = 2'd2;

  localparam logic [3:0] OP_NONE      = 4'd0;
  localparam logic [3:0] OP_LATCH     = 4'd1;
  localparam logic [3:0] OP_CLEAR     = 4'd2;
  localparam logic [3:0] OP_REG_WRITE = 4'd3;
  localparam logic [3:0] OP_KEY_RD    = 4'd4;
  localparam logic [3:0] OP_KEY_ON    = 4'd5;
  localparam logic [3:0] OP_REG_READ  = 4'd6;
  localparam logic [3:0] OP_OUT_READ  = 4'd7;
  localparam logic [3:0] OP_MEM_LOAD  = 4'd8;
  localparam logic [3:0] OP_TICK      = 4'd9;
  localparam logic [3:0] OP_OUT_TICK  = 4'd10;

  // per-voice tick steps
  localparam logic [3:0] TS_FREQ_HI = 4'd0;
  localparam logic [3:0] TS_FREQ_LO = 4'd1;
  localparam logic [3:0] TS_RVOL    = 4'd2;
  localparam logic [3:0] TS_LVOL    = 4'd3;
  localparam logic [3:0] TS_ADVANCE = 4'd4;
  localparam logic [3:0] TS_ENDCHK  = 4'd5;
  localparam logic [3:0] TS_FETCH   = 4'd6;
  localparam logic [3:0] TS_SAMPLE  = 4'd7;
  localparam logic [3:0] TS_SLOPE   = 4'd8;
  localparam logic [3:0] TS_INTERP  = 4'd9;
  localparam logic [3:0] TS_SCALE   = 4'd10;
  localparam logic [3:0] TS_MIX     = 4'd11;

  localparam logic [2:0] KSTEP_LAST = 3'd7;

  typedef struct packed {
    logic [3:0]        op;
    logic [3:0]        step;
    logic [VIDX_W-1:0] voice;
    logic [2:0]        kstep;
    logic [8:0]        clr_addr;
  } cmd_t;

  typedef struct packed {
    logic keyed;
    logic freq_zero;
    logic stop;
    logic is_key;
    logic key_bit;
    logic word_mode;
    logic out_busy;
  } status_t;

  // word-addressed variant: bank select register per group of four voices
  function automatic logic [8:0] bank_sel_addr(input logic [1:0] grp);
    logic [8:0] a;
    case (grp)
      2'd0:    a = 9'h1F7;
      2'd1:    a = 9'h1F1;
      2'd2:    a = 9'h1F3;
      default: a = 9'h1F5;
    endcase
    return a;
  endfunction

  // register bytes fetched at key-on: bank, start, end, loop
  function automatic logic [3:0] key_reg_idx(input logic [2:0] k);
    logic [3:0] i;
    case (k)
      3'd0:    i = 4'd4;
      3'd1:    i = 4'd6;
      3'd2:    i = 4'd7;
      3'd3:    i = 4'd8;
      3'd4:    i = 4'd9;
      3'd5:    i = 4'd10;
      default: i = 4'd11;
    endcase
    return i;
  endfunction

endpackage

[rtl/core/mvpcm_ctrl.sv]
// ----------------------------------------------------------------------------
// mvpcm_ctrl: sequencer for the PCM sample player
// Clearing pass, word dispatch, key-on fetch and the per-voice tick walk.
// ----------------------------------------------------------------------------
module mvpcm_ctrl #(
  parameter int VOICES = mvpcm_pkg::VOICES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_accept,
  input  logic [1:0]        in_func,
  input  mvpcm_pkg::status_t status,
  output logic              in_ready,
  output mvpcm_pkg::cmd_t   cmd
);
  import mvpcm_pkg::*;

  localparam int VB = $clog2(VOICES);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_WR    = 4'd2;
  localparam logic [3:0] S_KEY   = 4'd3;
  localparam logic [3:0] S_KEYON = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_RDOUT = 4'd6;
  localparam logic [3:0] S_LOAD  = 4'd7;
  localparam logic [3:0] S_TICK  = 4'd8;
  localparam logic [3:0] S_TOUT  = 4'd9;

  logic [3:0]    state, state_next;
  logic [8:0]    clr_cnt, clr_cnt_next;
  logic [2:0]    kstep, kstep_next;
  logic [VB-1:0] vcnt, vcnt_next;
  logic [3:0]    tstep, tstep_next;
  logic          last_voice, voice_done;

  assign in_ready   = (state == S_IDLE);
  assign last_voice = status.word_mode ? (vcnt == VB'(15)) : (vcnt == VB'(VOICES - 1));

  always_comb begin
    voice_done = 1'b0;
    case (tstep)
      TS_FREQ_HI: voice_done = !status.keyed;
      TS_LVOL:    voice_done = status.freq_zero;
      TS_ENDCHK:  voice_done = status.stop;
      TS_MIX:     voice_done = 1'b1;
      default:    voice_done = 1'b0;
    endcase
  end

  always_comb begin
    state_next   = state;
    clr_cnt_next = clr_cnt;
    kstep_next   = kstep;
    vcnt_next    = vcnt;
    tstep_next   = tstep;
    cmd.op       = OP_NONE;
    cmd.step     = tstep;
    cmd.voice    = VIDX_W'(vcnt);
    cmd.kstep    = kstep;
    cmd.clr_addr = clr_cnt;
    case (state)
      S_CLR: begin
        cmd.op       = OP_CLEAR;
        clr_cnt_next = clr_cnt + 9'd1;
        if (clr_cnt == 9'h1FF) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          cmd.op = OP_LATCH;
          case (in_func)
            FUNC_WRITE: state_next = S_WR;
            FUNC_READ:  state_next = S_RD;
            FUNC_TICK: begin
              state_next = S_TICK;
              vcnt_next  = '0;
              tstep_next = TS_FREQ_HI;
            end
            default:    state_next = S_LOAD;
          endcase
        end
      end
      S_WR: begin
        cmd.op = OP_REG_WRITE;
        if (status.is_key && status.key_bit) begin
          state_next = S_KEY;
          kstep_next = '0;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_KEY: begin
        cmd.op     = OP_KEY_RD;
        kstep_next = kstep + 3'd1;
        if (kstep == KSTEP_LAST) begin
          state_next = S_KEYON;
        end
      end
      S_KEYON: begin
        cmd.op     = OP_KEY_ON;
        state_next = S_IDLE;
      end
      S_RD: begin
        cmd.op     = OP_REG_READ;
        state_next = S_RDOUT;
      end
      S_RDOUT: begin
        cmd.op = OP_REG_READ;
        if (!status.out_busy) begin
          cmd.op     = OP_OUT_READ;
          state_next = S_IDLE;
        end
      end
      S_LOAD: begin
        cmd.op     = OP_MEM_LOAD;
        state_next = S_IDLE;
      end
      S_TICK: begin
        cmd.op     = OP_TICK;
        tstep_next = tstep + 4'd1;
        if (voice_done) begin
          tstep_next = TS_FREQ_HI;
          if (last_voice) begin
            state_next = S_TOUT;
          end else begin
            vcnt_next = vcnt + VB'(1);
          end
        end
      end
      S_TOUT: begin
        if (!status.out_busy) begin
          cmd.op     = OP_OUT_TICK;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      clr_cnt <= '0;
      kstep   <= '0;
      vcnt    <= '0;
      tstep   <= '0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
      kstep   <= kstep_next;
      vcnt    <= vcnt_next;
      tstep   <= tstep_next;
    end
  end

endmodule

[rtl/core/mvpcm_dp.sv]
// ----------------------------------------------------------------------------
// mvpcm_dp: datapath for the PCM sample player
// Register file, sample memory, voice state, interpolation, mixing and
// the output register.
// ----------------------------------------------------------------------------
module mvpcm_dp #(
  parameter int VOICES        = mvpcm_pkg::VOICES_DEF,
  parameter int MEM_ADDR_BITS = mvpcm_pkg::MEM_ADDR_BITS_DEF,
  parameter int IN_W          = 40
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_wdata,
  input  logic                       in_accept,
  input  logic [IN_W-1:0]            in_data,
  input  mvpcm_pkg::cmd_t            cmd,
  output mvpcm_pkg::status_t         status,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [mvpcm_pkg::OUT_W-1:0] out_data,
  output logic                       out_kind
);
  import mvpcm_pkg::*;

  localparam int VB = $clog2(VOICES);
  localparam int AW = MEM_ADDR_BITS;

  logic [1:0]    chip_type;
  logic [8:0]    in_off;
  logic [7:0]    in_val;
  logic [AW-1:0] in_addr;

  logic [7:0] rf [RF_DEPTH];
  logic [7:0] rf_q;
  logic [8:0] rf_raddr;
  logic       rf_we;
  logic [8:0] rf_waddr;
  logic [7:0] rf_wdata;

  logic [7:0]    sm [2**AW];
  logic [7:0]    sm_q;
  logic [AW-1:0] sm_raddr;

  logic [VOICES-1:0]  keyed;
  logic [15:0]        phase  [VOICES];
  logic signed [18:0] pos    [VOICES];
  logic signed [13:0] last_s [VOICES];
  logic signed [13:0] prev_s [VOICES];
  logic signed [14:0] slope  [VOICES];
  logic [7:0]         bank   [VOICES];
  logic [7:0]         mode   [VOICES];
  logic [16:0]        vstart [VOICES];
  logic [16:0]        vend   [VOICES];
  logic [16:0]        vloop  [VOICES];

  logic [7:0]         kb [7];
  logic [15:0]        w_freq;
  logic [7:0]         w_rraw, w_lraw;
  logic [1:0]         w_sel;
  logic [1:0]         w_cnt;
  logic [8:0]         w_lvol, w_rvol;
  logic signed [31:0] w_prod;
  logic signed [15:0] w_dt;
  logic signed [25:0] w_pl, w_pr;
  logic [15:0]        lsum, rsum;

  logic [7:0]  out_rd;
  logic [15:0] out_l, out_r;

  logic [VB-1:0]      vi, kvi;
  logic [8:0]         moff;
  logic [4:0]         vsel;
  logic signed [17:0] sz, loop_rel;
  logic               at_end, comp, word;
  logic [17:0]        phase_sum;
  logic [24:0]        bank_a;
  logic [25:0]        base, saddr;
  logic [17:0]        lmul, rmul;
  logic [2:0]         lexp;
  logic signed [13:0] ms, seg, exp_s, pcm_s, new_s;
  logic signed [25:0] pl_sh, pr_sh;

  assign word = (chip_type == CHIP_WORD);
  assign vi   = cmd.voice[VB-1:0];
  assign vsel = cmd.voice;
  assign moff = (word && in_off >= 9'h1F8) ? in_off - 9'd8 : in_off;
  assign kvi  = moff[4 +: VB];

  assign sz        = $signed({1'b0, vend[vi]}) - $signed({1'b0, vstart[vi]});
  assign loop_rel  = $signed({1'b0, vloop[vi]}) - $signed({1'b0, vstart[vi]});
  assign at_end    = pos[vi] >= $signed({sz[17], sz});
  assign comp      = mode[vi][3] && !word;
  assign phase_sum = {2'b00, phase[vi]} + {1'b0, w_freq, 1'b0};

  // banked sample base
  assign bank_a = {1'b0, bank[vi], 16'h0000} + {8'h00, vstart[vi]};
  always_comb begin
    case (chip_type)
      CHIP_A:    base = {6'd0, bank_a[21], bank_a[18:0]};
      CHIP_B:    base = {5'd0, bank_a[21:20], bank_a[18:0]};
      CHIP_WORD: base = {7'd0, w_sel, 17'h00000} + {1'b0, bank_a};
      default:   base = '0;
    endcase
  end
  assign saddr = base + {{7{pos[vi][18]}}, pos[vi]};

  // volume * 32 / 24 via reciprocal
  assign lmul = {10'd0, w_lraw} * 18'd683;
  assign rmul = {10'd0, w_rraw} * 18'd683;

  // log-compressed sample expansion
  assign lexp  = sm_q[2:0];
  assign ms    = $signed({{9{sm_q[7]}}, sm_q[7:3]}) <<< lexp;
  assign seg   = $signed({2'b00, (8'd1 << lexp) - 8'd1, 4'h0});
  assign exp_s = sm_q[7] ? ms - seg : ms + seg;

  always_comb begin
    pcm_s = $signed({{6{sm_q[7]}}, sm_q});
    if (word) begin
      if (mode[vi][0] && sm_q[7]) begin
        pcm_s = -$signed({7'd0, sm_q[6:0]});
      end
      if (mode[vi][6]) begin
        pcm_s = -pcm_s;
      end
    end
  end
  assign new_s = comp ? exp_s : pcm_s;

  assign pl_sh = comp ? (w_pl >>> 10) : (w_pl >>> 5);
  assign pr_sh = comp ? (w_pr >>> 10) : (w_pr >>> 5);

  // register file address selection
  always_comb begin
    rf_raddr = in_off;
    case (cmd.op)
      OP_KEY_RD: rf_raddr = {moff[8:4], key_reg_idx(cmd.kstep)};
      OP_TICK: begin
        case (cmd.step)
          TS_FREQ_HI: rf_raddr = {vsel, 4'd2};
          TS_FREQ_LO: rf_raddr = {vsel, 4'd3};
          TS_RVOL:    rf_raddr = {vsel, 4'd0};
          TS_LVOL:    rf_raddr = {vsel, 4'd1};
          default:    rf_raddr = bank_sel_addr(vsel[3:2]);
        endcase
      end
      default: rf_raddr = in_off;
    endcase
  end

  always_comb begin
    rf_we    = 1'b0;
    rf_waddr = moff;
    rf_wdata = in_val;
    case (cmd.op)
      OP_CLEAR: begin
        rf_we    = 1'b1;
        rf_waddr = cmd.clr_addr;
        rf_wdata = '0;
      end
      OP_REG_WRITE: rf_we = 1'b1;
      default:      rf_we = 1'b0;
    endcase
  end

  assign sm_raddr = saddr[AW-1:0];

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf[rf_waddr] <= rf_wdata;
    end
    rf_q <= rf[rf_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_MEM_LOAD) begin
      sm[in_addr] <= in_val;
    end
    sm_q <= sm[sm_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chip_type <= CHIP_A;
    end else if (cfg_we) begin
      chip_type <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_off  <= in_data[8:0];
      in_val  <= in_data[16:9];
      in_addr <= in_data[17 +: AW];
    end
  end

  // voice key state
  always_ff @(posedge clk) begin
    if (rst) begin
      keyed <= '0;
    end else begin
      if (cmd.op == OP_REG_WRITE && status.is_key && !in_val[7]) begin
        keyed[kvi] <= 1'b0;
      end
      if (cmd.op == OP_KEY_ON) begin
        keyed[kvi] <= 1'b1;
      end
      if (cmd.op == OP_TICK && cmd.step == TS_ENDCHK && status.stop) begin
        keyed[vi] <= 1'b0;
      end
    end
  end

  // voice payload and working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH: begin
        lsum <= '0;
        rsum <= '0;
      end
      OP_KEY_RD: begin
        if (cmd.kstep != 3'd0) begin
          kb[cmd.kstep - 3'd1] <= rf_q;
        end
      end
      OP_KEY_ON: begin
        phase[kvi]  <= '0;
        pos[kvi]    <= '0;
        last_s[kvi] <= '0;
        prev_s[kvi] <= '0;
        slope[kvi]  <= '0;
        bank[kvi]   <= kb[0];
        mode[kvi]   <= in_val;
        if (word) begin
          vstart[kvi] <= {kb[1], kb[2], 1'b0};
          vend[kvi]   <= {kb[3], kb[4], 1'b0};
          vloop[kvi]  <= {kb[5], kb[6], 1'b0};
        end else begin
          vstart[kvi] <= {1'b0, kb[1], kb[2]};
          vend[kvi]   <= {1'b0, kb[3], kb[4]};
          vloop[kvi]  <= {1'b0, kb[5], kb[6]};
        end
      end
      OP_TICK: begin
        case (cmd.step)
          TS_FREQ_LO: w_freq[15:8] <= rf_q;
          TS_RVOL:    w_freq[7:0]  <= rf_q;
          TS_LVOL:    w_rraw       <= rf_q;
          TS_ADVANCE: begin
            w_lraw    <= rf_q;
            w_cnt     <= phase_sum[17:16];
            phase[vi] <= phase_sum[15:0];
            pos[vi]   <= pos[vi] + {17'd0, phase_sum[17:16]};
          end
          TS_ENDCHK: begin
            w_sel  <= rf_q[1:0];
            w_lvol <= lmul[17:9];
            w_rvol <= rmul[17:9];
            if (at_end && mode[vi][4]) begin
              pos[vi] <= {loop_rel[17], loop_rel};
            end
          end
          TS_SAMPLE: begin
            if (comp || w_cnt != 2'd0) begin
              prev_s[vi] <= last_s[vi];
              last_s[vi] <= new_s;
              slope[vi]  <= {new_s[13], new_s} - {last_s[vi][13], last_s[vi]};
            end
          end
          TS_SLOPE:  w_prod <= slope[vi] * $signed({1'b0, phase[vi]});
          TS_INTERP: w_dt <= w_prod[31:16] + {{2{prev_s[vi][13]}}, prev_s[vi]};
          TS_SCALE: begin
            w_pl <= w_dt * $signed({1'b0, w_lvol});
            w_pr <= w_dt * $signed({1'b0, w_rvol});
          end
          TS_MIX: begin
            lsum <= lsum + pl_sh[15:0];
            rsum <= rsum + pr_sh[15:0];
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_OUT_READ || cmd.op == OP_OUT_TICK) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT_READ) begin
      out_kind <= 1'b0;
      out_rd   <= rf_q;
      out_l    <= '0;
      out_r    <= '0;
    end else if (cmd.op == OP_OUT_TICK) begin
      out_kind <= 1'b1;
      out_rd   <= '0;
      out_l    <= lsum;
      out_r    <= rsum;
    end
  end

  assign out_data = {out_r, out_l, out_rd};

  assign status.keyed     = keyed[vi];
  assign status.freq_zero = (w_freq == 16'h0000);
  assign status.stop      = at_end && !mode[vi][4];
  assign status.is_key    = ({1'b0, moff[8:4]} < 6'(VOICES)) && (moff[3:0] == 4'd5);
  assign status.key_bit   = in_val[7];
  assign status.word_mode = word;
  assign status.out_busy  = out_valid && !out_ready;

endmodule

[rtl/core/multi_voice_pcm_sample_player_unit.sv]
// ----------------------------------------------------------------------------
// multi_voice_pcm_sample_player_unit: wavetable PCM sample player top level
// Register file driven multi-voice sample playback with stereo mixing.
// ----------------------------------------------------------------------------
// Usage
//   Input stream (s_*): one word per command; s_tuser picks the function
//   (register write, register read, output tick, sample memory load).
//   Output stream (m_*): one word per register read or tick; m_tuser is 0
//   for read data, 1 for a mixed stereo sample. Writes and loads give none.
//   cfg_we/cfg_wdata set the chip type; write it only while idle.
// Sequencing
//   A write that sets a key bit also fetches seven register bytes for
//   key-on. A tick walks the voices in turn through the single register
//   file read port, ending a voice early when it is not keyed, has zero
//   frequency or has stopped at its end; 16 voices in the word-addressed
//   type, VOICES otherwise.
// Reset
//   After rst the register file is swept to zero, one byte a cycle, all
//   512 bytes with s_tready low. Voices come up keyed off.
// Back-pressure
//   A finished word waits in the output register; the sequencer holds the
//   next result until it is taken, and takes no new word meanwhile.
// ----------------------------------------------------------------------------
module multi_voice_pcm_sample_player_unit #(
  parameter int VOICES        = mvpcm_pkg::VOICES_DEF,
  parameter int MEM_ADDR_BITS = mvpcm_pkg::MEM_ADDR_BITS_DEF,
  parameter int IN_W          = ((17 + MEM_ADDR_BITS + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_wdata,   // chip_type
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [IN_W-1:0]             s_tdata,     // reg_offset, byte_value, mem_address
  input  logic [1:0]                  s_tuser,     // func
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [mvpcm_pkg::OUT_W-1:0] m_tdata,     // read_data, left_out, right_out
  output logic                        m_tuser      // result_kind
);
  import mvpcm_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_accept;

  assign in_accept = s_tvalid & s_tready;

  mvpcm_ctrl #(
    .VOICES (VOICES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .in_func   (s_tuser),
    .status    (status),
    .in_ready  (s_tready),
    .cmd       (cmd)
  );

  mvpcm_dp #(
    .VOICES        (VOICES),
    .MEM_ADDR_BITS (MEM_ADDR_BITS),
    .IN_W          (IN_W)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_accept (in_accept),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_kind  (m_tuser)
  );

endmodule
